// ===== rtl/core/cgt_pkg.sv =====
// shared types, constants and small tables for the calendar / gps time converter
`default_nettype none
package cgt_pkg;

  localparam logic CMD_CAL_TO_GPS = 1'b0;
  localparam logic CMD_GPS_TO_CAL = 1'b1;

  // number of register stages in each conversion datapath
  localparam int PIPE_DEPTH = 6;

  typedef struct packed {
    logic        command;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [15:0] milli_second;
    logic [14:0] week;
    logic [29:0] ms_of_week;
  } in_t;

  typedef struct packed {
    logic [14:0] week_out;
    logic [29:0] ms_of_week_out;
    logic [11:0] year_out;
    logic [3:0]  month_out;
    logic [4:0]  day_out;
    logic [4:0]  hour_out;
    logic [5:0]  minute_out;
    logic [15:0] milli_second_out;
    logic        invalid;
  } out_t;

  typedef struct packed {
    logic        bad;
    logic [14:0] week;
    logic [29:0] ms;
  } c2g_res_t;

  typedef struct packed {
    logic        bad;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [15:0] msec;
  } g2c_res_t;

  // calendar sum at the gps epoch: 679019 + 44244
  localparam logic [20:0] EPOCH_SUM = 21'd723263;
  // gps epoch mjd + 2400001 + 1537
  localparam logic [21:0] B_BASE = 22'd2445782;
  localparam logic [25:0] B_OFS = 26'd2442;

  // reciprocals, exact over the operand ranges used
  localparam int DIV7_K = 21;
  localparam logic [18:0] DIV7_M = 19'(((64'd1 << DIV7_K) + 64'd6) / 64'd7);
  localparam int CDIV_K = 39;
  localparam logic [26:0] CDIV_M = 27'(((64'd1 << CDIV_K) + 64'd7304) / 64'd7305);
  localparam int EDIV_K = 30;
  localparam logic [25:0] EDIV_M = 26'(((64'd10000 << EDIV_K) + 64'd306000) / 64'd306001);
  localparam int HDIV_K = 49;
  localparam logic [27:0] HDIV_M = 28'(((64'd1 << HDIV_K) + 64'd3599999) / 64'd3600000);
  localparam int MDIV_K = 38;
  localparam logic [22:0] MDIV_M = 23'(((64'd1 << MDIV_K) + 64'd59999) / 64'd60000);

  // floor(30.6001 * x)
  function automatic logic [8:0] month_days(input logic [3:0] x);
    logic [8:0] r;
    case (x)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd30;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd91;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd183;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd244;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd336;
      4'd12:   r = 9'd367;
      4'd13:   r = 9'd397;
      4'd14:   r = 9'd428;
      4'd15:   r = 9'd459;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // day of week times ms per day
  function automatic logic [29:0] day_ms(input logic [2:0] d);
    logic [29:0] r;
    case (d)
      3'd0:    r = 30'd0;
      3'd1:    r = 30'd86400000;
      3'd2:    r = 30'd172800000;
      3'd3:    r = 30'd259200000;
      3'd4:    r = 30'd345600000;
      3'd5:    r = 30'd432000000;
      3'd6:    r = 30'd518400000;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/cgt_c2g.sv =====
// calendar to gps week / ms of week datapath
`default_nettype none
module cgt_c2g (
  input  wire logic            clk,
  input  wire logic            en,
  input  wire cgt_pkg::in_t    din,
  output cgt_pkg::c2g_res_t    res
);

  // stage 1
  logic        bad1_r;
  logic [20:0] a1_r;
  logic [8:0]  t1_r;
  logic [4:0]  day1_r;
  logic [26:0] hms1_r;
  logic [21:0] mims1_r;
  logic [15:0] msec1_r;
  // stage 2
  logic        bad2_r;
  logic [17:0] dd2_r;
  logic [26:0] tod2_r;
  // stage 3
  logic        bad3_r;
  logic [17:0] dd3_r;
  logic [36:0] qp3_r;
  logic [26:0] tod3_r;
  // stage 4..6
  cgt_pkg::c2g_res_t res4_r, res5_r, res6_r;

  logic        bad1_nxt;
  logic [11:0] y1;
  logic [3:0]  m1;
  logic [20:0] s2;
  logic [14:0] w4;
  logic [2:0]  r4;

  always_comb begin
    bad1_nxt = (din.year < 12'd1980) || (din.year > 12'd2399) ||
               (din.month < 4'd1) || (din.month > 4'd12) ||
               (din.day < 5'd1) || (din.hour > 5'd23) ||
               (din.minute > 6'd59) || (din.milli_second > 16'd59999);
    if (din.month <= 4'd2) begin
      y1 = din.year - 12'd1;
      m1 = din.month + 4'd13;
    end else begin
      y1 = din.year;
      m1 = din.month + 4'd1;
    end
    s2 = a1_r + 21'(t1_r) + 21'(day1_r);
    w4 = qp3_r[35:21];
    r4 = 3'(dd3_r - 18'(w4) * 18'd7);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bad1_r  <= bad1_nxt;
      a1_r    <= 21'((23'(y1) * 23'd1461) >> 2);
      t1_r    <= cgt_pkg::month_days(m1);
      day1_r  <= din.day;
      hms1_r  <= 27'(din.hour) * 27'd3600000;
      mims1_r <= 22'(din.minute) * 22'd60000;
      msec1_r <= din.milli_second;

      bad2_r <= bad1_r || (s2 < cgt_pkg::EPOCH_SUM);
      dd2_r  <= 18'(s2 - cgt_pkg::EPOCH_SUM);
      tod2_r <= hms1_r + 27'(mims1_r) + 27'(msec1_r);

      bad3_r <= bad2_r;
      dd3_r  <= dd2_r;
      qp3_r  <= 37'(dd2_r) * 37'(cgt_pkg::DIV7_M);
      tod3_r <= tod2_r;

      res4_r.bad  <= bad3_r;
      res4_r.week <= w4;
      res4_r.ms   <= cgt_pkg::day_ms(r4) + 30'(tod3_r);

      res5_r <= res4_r;
      res6_r <= res5_r;
    end
  end

  assign res = res6_r;

endmodule
`default_nettype wire

// ===== rtl/core/cgt_g2c.sv =====
// gps week / ms of week to calendar datapath
`default_nettype none
module cgt_g2c (
  input  wire logic            clk,
  input  wire logic            en,
  input  wire cgt_pkg::in_t    din,
  output cgt_pkg::g2c_res_t    res
);

  logic        bad1_r, bad2_r, bad3_r, bad4_r, bad5_r;
  logic [2:0]  dow1_r;
  logic [17:0] wk71_r;
  logic [29:0] mow1_r;
  logic [21:0] b2_r, b3_r;
  logic [25:0] n2_r;
  logic [26:0] tod2_r, tod3_r;
  logic [52:0] cp3_r;
  logic [54:0] hp3_r;
  logic [12:0] c4_r, c5_r;
  logic [9:0]  x4_r, x5_r;
  logic [4:0]  h4_r, h5_r;
  logic [21:0] rem4_r, rem5_r;
  logic [34:0] ep5_r;
  logic [44:0] mp5_r;
  cgt_pkg::g2c_res_t res6_r;

  logic [2:0]  dow_nxt;
  logic [21:0] bsum;
  logic [12:0] c4;
  logic [21:0] d4;
  logic [4:0]  h4;
  logic [3:0]  e6;
  logic [3:0]  mon6;
  logic [5:0]  mi6;

  always_comb begin
    dow_nxt = 3'd0;
    for (int k = 1; k < 7; k++) begin
      if (din.ms_of_week >= 30'(k * 86400000)) dow_nxt = 3'(k);
    end
    bsum = cgt_pkg::B_BASE + 22'(wk71_r) + 22'(dow1_r);
    c4   = cp3_r[51:39];
    d4   = 22'((24'(c4) * 24'd1461) >> 2);
    h4   = hp3_r[53:49];
    e6   = ep5_r[33:30];
    mon6 = (e6 >= 4'd14) ? e6 - 4'd13 : e6 - 4'd1;
    mi6  = mp5_r[43:38];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bad1_r <= (din.week > 15'd22000) || (din.ms_of_week >= 30'd604800000);
      dow1_r <= dow_nxt;
      wk71_r <= 18'(din.week) * 18'd7;
      mow1_r <= din.ms_of_week;

      bad2_r <= bad1_r;
      b2_r   <= bsum;
      n2_r   <= 26'(bsum) * 26'd20 - cgt_pkg::B_OFS;
      tod2_r <= 27'(mow1_r - cgt_pkg::day_ms(dow1_r));

      bad3_r <= bad2_r;
      b3_r   <= b2_r;
      tod3_r <= tod2_r;
      cp3_r  <= 53'(n2_r) * 53'(cgt_pkg::CDIV_M);
      hp3_r  <= 55'(tod2_r) * 55'(cgt_pkg::HDIV_M);

      bad4_r <= bad3_r;
      c4_r   <= c4;
      x4_r   <= 10'(b3_r - d4);
      h4_r   <= h4;
      rem4_r <= 22'(tod3_r - 27'(h4) * 27'd3600000);

      bad5_r <= bad4_r;
      c5_r   <= c4_r;
      x5_r   <= x4_r;
      h5_r   <= h4_r;
      rem5_r <= rem4_r;
      ep5_r  <= 35'(x4_r) * 35'(cgt_pkg::EDIV_M);
      mp5_r  <= 45'(rem4_r) * 45'(cgt_pkg::MDIV_M);

      res6_r.bad    <= bad5_r;
      res6_r.year   <= 12'(c5_r - 13'd4715 - ((mon6 >= 4'd3) ? 13'd1 : 13'd0));
      res6_r.month  <= mon6;
      res6_r.day    <= 5'(x5_r - 10'(cgt_pkg::month_days(e6)));
      res6_r.hour   <= h5_r;
      res6_r.minute <= mi6;
      res6_r.msec   <= 16'(rem5_r - 22'(mi6) * 22'd60000);
    end
  end

  assign res = res6_r;

endmodule
`default_nettype wire

// ===== rtl/core/calendar_gps_time_converter_unit.sv =====
// Calendar <-> GPS week / time-of-week converter, top level.
// Input channel in_valid / in_stall / in_data carries one conversion request;
// in_data.command selects calendar to gps (0) or gps to calendar (1).
// Result channel out_valid / out_stall / out_data returns exactly one result
// per request, in order. Fields of the unused direction are zero, and an
// out-of-range or pre-epoch request returns invalid = 1 with all else zero.
// The path is six datapath stages (reciprocal multiplies for the
// divisions by 7, 7305, 306001/10000, 3600000 and 60000) plus the output
// register. Throughput is one transaction per cycle while out_stall does not hold a result.
// When out_stall holds a pending result, the whole pipeline freezes and
// in_stall is raised; nothing is lost or repeated.
// Reset clears all valid flags; the data registers are not reset.
`default_nettype none
module calendar_gps_time_converter_unit (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire cgt_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output cgt_pkg::out_t      out_data
);

  localparam int D = cgt_pkg::PIPE_DEPTH;

  logic [D-1:0]      vld_r;
  logic [D-1:0]      cmd_r;
  logic              out_valid_r;
  cgt_pkg::out_t     out_data_r;
  cgt_pkg::out_t     res_nxt;
  cgt_pkg::c2g_res_t c2g_res;
  cgt_pkg::g2c_res_t g2c_res;
  logic              en;

  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  cgt_c2g u_c2g (.clk(clk), .en(en), .din(in_data), .res(c2g_res));
  cgt_g2c u_g2c (.clk(clk), .en(en), .din(in_data), .res(g2c_res));

  always_comb begin
    res_nxt = '0;
    if (cmd_r[D-1] == cgt_pkg::CMD_CAL_TO_GPS) begin
      if (c2g_res.bad) begin
        res_nxt.invalid = 1'b1;
      end else begin
        res_nxt.week_out       = c2g_res.week;
        res_nxt.ms_of_week_out = c2g_res.ms;
      end
    end else begin
      if (g2c_res.bad) begin
        res_nxt.invalid = 1'b1;
      end else begin
        res_nxt.year_out         = g2c_res.year;
        res_nxt.month_out        = g2c_res.month;
        res_nxt.day_out          = g2c_res.day;
        res_nxt.hour_out         = g2c_res.hour;
        res_nxt.minute_out       = g2c_res.minute;
        res_nxt.milli_second_out = g2c_res.msec;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[D-2:0], in_valid};
      out_valid_r <= vld_r[D-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cmd_r <= {cmd_r[D-2:0], in_data.command};
      if (vld_r[D-1]) out_data_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.invalid) |->
      (out_data_r.week_out == '0 && out_data_r.ms_of_week_out == '0 &&
       out_data_r.year_out == '0 && out_data_r.month_out == '0))
    else $error("invalid result carries nonzero fields");

  a_gps_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.invalid && out_data_r.month_out == '0) |->
      (out_data_r.ms_of_week_out < 30'd604800000 && out_data_r.year_out == '0))
    else $error("gps result out of range");

  a_cal_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.invalid && out_data_r.month_out != '0) |->
      (out_data_r.month_out <= 4'd12 && out_data_r.day_out != '0 &&
       out_data_r.week_out == '0 && out_data_r.ms_of_week_out == '0))
    else $error("calendar result out of range");

  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r))
    else $error("pipeline moved during stall");
`endif

endmodule
`default_nettype wire

// ===== tb/calendar_gps_time_converter_unit_checker.sv =====
// checker for the calendar / gps time converter: predicts each result and compares it
module calendar_gps_time_converter_unit_checker (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_stall,
  input  cgt_pkg::in_t   in_data,
  input  logic           out_valid,
  input  logic           out_stall,
  input  cgt_pkg::out_t  out_data,
  output int             n_errors,
  output int             n_pending,
  output int             n_results,
  output int             n_invalid
);

  cgt_pkg::out_t pending_conversions[$];

  function automatic cgt_pkg::out_t convert_time(input cgt_pkg::in_t t);
    cgt_pkg::out_t r;
    longint year, month, day, y, m, mjd, elapsed;
    longint week, mow, tod, b, c, d, e, dd, mon, yr;
    r = '0;
    if (t.command == cgt_pkg::CMD_CAL_TO_GPS) begin
      year = t.year;
      month = t.month;
      day = t.day;
      if (year < 1980 || year > 2399 || month < 1 || month > 12 || day < 1 || day > 31 ||
          t.hour > 23 || t.minute > 59 || t.milli_second > 59999) begin
        r.invalid = 1'b1;
        return r;
      end
      if (month <= 2) begin
        y = year - 1;
        m = month + 12;
      end else begin
        y = year;
        m = month;
      end
      mjd = (1461 * y) / 4 + (306001 * (m + 1)) / 10000 + day - 679019;
      if (mjd < 44244) begin
        r.invalid = 1'b1;
        return r;
      end
      elapsed = (mjd - 44244) * 64'd86400000 + longint'(t.hour) * 3600000
              + longint'(t.minute) * 60000 + longint'(t.milli_second);
      r.week_out = 15'(elapsed / 64'd604800000);
      r.ms_of_week_out = 30'(elapsed % 64'd604800000);
    end else begin
      week = t.week;
      mow = t.ms_of_week;
      if (week > 22000 || mow >= 604800000) begin
        r.invalid = 1'b1;
        return r;
      end
      mjd = 44244 + week * 7 + mow / 86400000;
      tod = mow % 86400000;
      b = mjd + 2400001 + 1537;
      c = (20 * b - 2442) / 7305;
      d = (1461 * c) / 4;
      e = ((b - d) * 10000) / 306001;
      dd = b - d - (306001 * e) / 10000;
      mon = e - 1 - 12 * (e / 14);
      yr = c - 4715 - ((7 + mon) / 10);
      r.year_out = 12'(yr);
      r.month_out = 4'(mon);
      r.day_out = 5'(dd);
      r.hour_out = 5'(tod / 3600000);
      r.minute_out = 6'((tod / 60000) % 60);
      r.milli_second_out = 16'(tod % 60000);
    end
    return r;
  endfunction

  assign n_pending = pending_conversions.size();

  initial begin
    n_errors = 0;
    n_results = 0;
    n_invalid = 0;
  end

  always @(posedge clk) begin
    cgt_pkg::out_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) pending_conversions.push_back(convert_time(in_data));
      if (out_valid && !out_stall) begin
        n_results++;
        if (out_data.invalid) n_invalid++;
        if (pending_conversions.size() == 0) begin
          n_errors++;
          if (n_errors <= 10) $display("unexpected transaction: %p", out_data);
        end else begin
          want = pending_conversions.pop_front();
          if (want !== out_data) begin
            n_errors++;
            if (n_errors <= 10) $display("mismatch: expected %p actual %p", want, out_data);
          end
        end
      end
    end
  end
endmodule

// ===== tb/calendar_gps_time_converter_unit_test.sv =====
// stimulus and verdict for the calendar / gps time converter
module calendar_gps_time_converter_unit_test;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  cgt_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  cgt_pkg::out_t out_data;
  int n_errors, n_pending, n_results, n_invalid;
  int hold_cycles = 0;
  bit stall_done = 1'b0;

  calendar_gps_time_converter_unit dut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  calendar_gps_time_converter_unit_checker chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .n_errors(n_errors), .n_pending(n_pending), .n_results(n_results), .n_invalid(n_invalid)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("RESULT: ERROR");
    $finish;
  end

  // receiver: one long hold-off early on, then a random stall pattern
  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else if (!stall_done && hold_cycles < 60) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles + 1;
    end else begin
      stall_done <= 1'b1;
      out_stall <= (($urandom_range(0, 99) < 40) && ($urandom_range(0, 3) != 0))
                   ? (($urandom_range(0, 1)) == 1) : 1'b0;
    end
  end

  function automatic cgt_pkg::in_t make_cal(int yr, int mo, int dy, int hr, int mi, int ms);
    cgt_pkg::in_t t;
    t = '0;
    t.command = cgt_pkg::CMD_CAL_TO_GPS;
    t.year = 12'(yr);
    t.month = 4'(mo);
    t.day = 5'(dy);
    t.hour = 5'(hr);
    t.minute = 6'(mi);
    t.milli_second = 16'(ms);
    t.week = 15'($urandom);
    t.ms_of_week = 30'($urandom);
    return t;
  endfunction

  function automatic cgt_pkg::in_t make_gps(int wk, int mow);
    cgt_pkg::in_t t;
    t = cgt_pkg::in_t'({$urandom, $urandom, $urandom, $urandom});
    t.command = cgt_pkg::CMD_GPS_TO_CAL;
    t.week = 15'(wk);
    t.ms_of_week = 30'(mow);
    return t;
  endfunction

  function automatic cgt_pkg::in_t random_item();
    int k;
    k = $urandom_range(0, 99);
    if (k < 8) return cgt_pkg::in_t'({$urandom, $urandom, $urandom, $urandom});
    if (k < 50)
      return make_cal($urandom_range(1980, 2399), $urandom_range(1, 12),
                      $urandom_range(1, 31), $urandom_range(0, 23),
                      $urandom_range(0, 59), $urandom_range(0, 59999));
    if (k < 56)
      return make_cal($urandom_range(0, 4095), $urandom_range(0, 15), $urandom_range(0, 31),
                      $urandom_range(0, 31), $urandom_range(0, 63), $urandom_range(0, 65535));
    if (k < 94) return make_gps($urandom_range(0, 22000), $urandom_range(0, 604799999));
    return make_gps($urandom_range(0, 32767), $urandom_range(0, 1073741823));
  endfunction

  // offer one transaction and hold it until accepted
  task automatic send(input cgt_pkg::in_t t);
    in_valid <= 1'b1;
    in_data <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic idle(input int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  cgt_pkg::in_t directed_items[$];
  int guard;

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed_items = '{
      make_cal(1980, 1, 6, 0, 0, 0), make_cal(1980, 1, 5, 23, 59, 59999),
      make_cal(2399, 12, 31, 23, 59, 59999), make_cal(2400, 1, 1, 0, 0, 0),
      make_cal(1979, 12, 31, 0, 0, 0), make_cal(2024, 0, 10, 0, 0, 0),
      make_cal(2024, 13, 10, 0, 0, 0), make_cal(2024, 5, 0, 0, 0, 0),
      make_cal(2024, 2, 30, 12, 30, 30000), make_cal(2023, 4, 31, 0, 0, 0),
      make_cal(2024, 5, 5, 24, 0, 0), make_cal(2024, 5, 5, 0, 60, 0),
      make_cal(2024, 5, 5, 0, 0, 60000), make_cal(4095, 15, 31, 31, 63, 65535),
      make_gps(0, 0), make_gps(22000, 604799999), make_gps(22001, 0),
      make_gps(0, 604800000), make_gps(32767, 1073741823), make_gps(2300, 86399999),
      make_gps(1042, 345600000), make_gps(21999, 518400000)
    };
    // long receiver hold-off is running now; keep offering so the pipe fills
    foreach (directed_items[i]) send(directed_items[i]);
    // drain completely before the random part
    idle(1);
    while (n_pending != 0) @(posedge clk);
    for (int i = 0; i < 550; i++) begin
      if (($urandom_range(0, 9) == 0) && (i > 100)) idle($urandom_range(1, 12));
      send(random_item());
      if (i % 40 == 39) begin
        // sender waits out every outstanding result
        idle(1);
        while (n_pending != 0) @(posedge clk);
      end
    end
    in_valid <= 1'b0;
    guard = 0;
    while (n_pending != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (20) @(posedge clk);
    $display("covered %0d conversions (%0d flagged invalid), both directions with random idling",
             n_results, n_invalid);
    if (n_errors == 0 && n_pending == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule
